// ===== rtl/ftm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftm_pkg: shared constants for the filmic tone mapper
// Fixed-point constants of the rational curve and the pipeline depth.
// ----------------------------------------------------------------------------
package ftm_pkg;

	// Pipeline depth of one lane, input register to output register
	localparam int NUM_STAGES = 24;

	// Number of quotient bits of the ratio, one per divider stage
	localparam int DIV_BITS = 16;

	// Offset 0.004 in Q4.12
	localparam logic [15:0] OFFSET_Q12 = 16'd16;
	// 6.2 in Q16
	localparam logic [18:0] K62_Q16 = 19'd406323;
	// 0.5 and 1.7 in Q28
	localparam logic [35:0] K05_Q28 = 36'd134217728;
	localparam logic [35:0] K17_Q28 = 36'd456340275;
	// 0.06 in Q40
	localparam logic [51:0] K006_Q40 = 52'd65970697667;

	// Per-stage load enables from the flow control to the lanes
	typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

// ===== rtl/ftm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftm_ctrl: pipeline flow control
// Tracks a valid bit per stage and lets each stage load whenever its slot is
// empty or its contents move on, so bubbles are squeezed out under stall.
// ----------------------------------------------------------------------------
module ftm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ftm_pkg::stage_en_t stage_en
);
	import ftm_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] rdy;

	// Build the ready chain from the output back to the input
	always_comb begin
		rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	assign stage_en  = rdy;
	assign in_ready  = rdy[0];
	assign out_valid = valid_q[NUM_STAGES-1];

	// Advance valid bits with their stage loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

endmodule

// ===== rtl/ftm_lane.sv =====
// ----------------------------------------------------------------------------
// ftm_lane: one color channel of the tone mapper
// Exposure, offset, rational filmic curve with a bit-per-stage divider, and
// a power-2.4 lookup with linear interpolation from a constant ROM.
// ----------------------------------------------------------------------------
module ftm_lane #(
	parameter int POW_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  ftm_pkg::stage_en_t stage_en,
	input  logic [15:0]        gain,
	input  logic [15:0]        chan_in,
	output logic [15:0]        chan_out
);
	import ftm_pkg::*;

	localparam int AW = $clog2(POW_TABLE_DEPTH + 1);
	localparam int PW = 16 + AW;

	typedef logic [16:0] pow_tab_t [POW_TABLE_DEPTH+1];

	// Power table: a^2.4 = a*a*a^0.4 with the fifth root found by bisection
	function automatic pow_tab_t build_tab();
		pow_tab_t   tab;
		logic [63:0] a;
		logic [63:0] sq;
		logic [63:0] v;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
			a  = (64'(i) << 16) / POW_TABLE_DEPTH;
			sq = a * a;
			v  = sq << 28;
			lo = 64'd0;
			hi = 64'd4096;
			for (int k = 0; k < 14; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (mid * mid * mid * mid * mid <= v) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			tab[i] = 17'((sq * lo) >> 28);
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_tab();

	logic [31:0] prod_s1;
	logic [15:0] x_s2;
	logic [15:0] x_s3;
	logic [34:0] t_s3;
	logic [33:0] nlo_s4, nhi_s4, dlo_s4, dhi_s4;
	logic [38:0] n_s5, d_s5;
	logic [38:0] div_rem_s [DIV_BITS];
	logic [38:0] div_den_s [DIV_BITS];
	logic [15:0] div_quo_s [DIV_BITS];
	logic [16:0] lo_s22, hi_s22;
	logic [15:0] w_s22;
	logic [16:0] lo_s23;
	logic [33:0] prod_s23;
	logic [15:0] out_s24;

	logic [32:0] rnd;
	logic [24:0] s_full;
	logic [15:0] s_sat;
	logic [35:0] a_sum, b_sum;
	logic [51:0] num, den;
	logic [PW-1:0] pos;
	logic [AW-1:0] idx, idx1;
	logic [16:0] hi_c;
	logic [16:0] diff;
	logic [17:0] res;

	// Scale by exposure
	always_ff @(posedge clk) begin
		if (stage_en[0]) prod_s1 <= chan_in * gain;
	end

	// Round, saturate, remove the offset
	always_comb begin
		rnd    = {1'b0, prod_s1} + 33'd128;
		s_full = rnd[32:8];
		s_sat  = (s_full > 25'd65535) ? 16'hFFFF : s_full[15:0];
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) x_s2 <= (s_sat > OFFSET_Q12) ? (s_sat - OFFSET_Q12) : 16'd0;
	end

	// t = 6.2 x
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			t_s3 <= 35'(K62_Q16 * x_s2);
			x_s3 <= x_s2;
		end
	end

	// Split products of numerator and denominator
	assign a_sum = {1'b0, t_s3} + K05_Q28;
	assign b_sum = {1'b0, t_s3} + K17_Q28;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			nlo_s4 <= x_s3 * a_sum[17:0];
			nhi_s4 <= x_s3 * a_sum[35:18];
			dlo_s4 <= x_s3 * b_sum[17:0];
			dhi_s4 <= x_s3 * b_sum[35:18];
		end
	end

	// Combine partial products and drop the low bits
	assign num = {18'd0, nlo_s4} + {nhi_s4, 18'd0};
	assign den = {18'd0, dlo_s4} + {dhi_s4, 18'd0} + K006_Q40;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			n_s5 <= num[50:12];
			d_s5 <= den[50:12];
		end
	end

	// Divide n/d, one quotient bit per stage; n < d always holds
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [38:0] rem_in;
		logic [38:0] den_in;
		logic [15:0] quo_in;
		logic [39:0] r2;
		logic        take;
		if (k == 0) begin : g_first
			assign rem_in = n_s5;
			assign den_in = d_s5;
			assign quo_in = 16'd0;
		end else begin : g_next
			assign rem_in = div_rem_s[k-1];
			assign den_in = div_den_s[k-1];
			assign quo_in = div_quo_s[k-1];
		end
		assign r2   = {rem_in, 1'b0};
		assign take = (r2 >= {1'b0, den_in});
		always_ff @(posedge clk) begin
			if (stage_en[5+k]) begin
				div_rem_s[k] <= take ? 39'(r2 - {1'b0, den_in}) : r2[38:0];
				div_den_s[k] <= den_in;
				div_quo_s[k] <= {quo_in[14:0], take};
			end
		end
	end

	// Table position and ROM read of both neighbors
	assign pos  = PW'(div_quo_s[DIV_BITS-1]) * PW'(POW_TABLE_DEPTH);
	assign idx  = pos[PW-1:16];
	assign idx1 = idx + AW'(1);

	always_ff @(posedge clk) begin
		if (stage_en[21]) begin
			lo_s22 <= POW_TAB[idx];
			hi_s22 <= POW_TAB[idx1];
			w_s22  <= pos[15:0];
		end
	end

	// Interpolation weight product
	assign hi_c = (hi_s22 < lo_s22) ? lo_s22 : hi_s22;
	assign diff = hi_c - lo_s22;

	always_ff @(posedge clk) begin
		if (stage_en[22]) begin
			prod_s23 <= 34'(diff * w_s22) + 34'd32768;
			lo_s23   <= lo_s22;
		end
	end

	// Add and clamp into the output register
	assign res = {1'b0, lo_s23} + prod_s23[33:16];

	always_ff @(posedge clk) begin
		if (stage_en[23]) out_s24 <= (res > 18'd65535) ? 16'hFFFF : res[15:0];
	end

	assign chan_out = out_s24;

endmodule

// ===== rtl/filmic_tone_map_rgb.sv =====
// ----------------------------------------------------------------------------
// filmic_tone_map_rgb: filmic tone mapper for linear HDR RGB pixels
// Three parallel lanes apply exposure, a rational filmic curve and a 2.4
// power; their outputs are merged into one result beat.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock cycle while the output keeps taking results,
// and its result leaves the output register after the 16-stage ratio divider
// and the exposure, curve and table lookup stages. Each stage loads when empty
// or draining, so input keeps flowing while a finished pixel waits on the
// output, until every stage is full. The exposure gain (Q8.8, reset 1.0) should
// be written only while no pixel is in flight. The power table is a constant
// ROM of POW_TABLE_DEPTH+1 entries per lane and needs no fill after reset.
module filmic_tone_map_rgb #(
	parameter int POW_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // red_out, green_out, blue_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // exposure_gain
);
	import ftm_pkg::*;

	logic [15:0] gain_q;
	stage_en_t   stage_en;
	logic [15:0] lane_out [3];

	// Hold the exposure gain
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd256;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	ftm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stage_en  (stage_en)
	);

	// One lane per color channel
	for (genvar c = 0; c < 3; c++) begin : g_lane
		ftm_lane #(
			.POW_TABLE_DEPTH (POW_TABLE_DEPTH)
		) u_lane (
			.clk      (clk),
			.stage_en (stage_en),
			.gain     (gain_q),
			.chan_in  (s_tdata[16*c +: 16]),
			.chan_out (lane_out[c])
		);
	end

	// Merge lane results into one beat
	assign m_tdata = {lane_out[2], lane_out[1], lane_out[0]};

endmodule

// ===== dv/ftm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_checker: result predictor and scoreboard for the filmic tone mapper
// Watches the pixel, result and gain channels, computes the expected tone
// mapped pixel for every accepted input beat and compares each result beat.
// ----------------------------------------------------------------------------
module ftm_checker #(
	parameter int POW_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [15:0] gain_q8;
	logic [31:0] pow_lut [0:POW_TABLE_DEPTH];
	logic [47:0] pixel_q [$];

	function automatic longint unsigned root5_q12(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 4096;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid * mid * mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// Build the 2.4 power table once
	initial begin
		longint unsigned a, sq;
		for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
			a = (longint'(i) << 16) / POW_TABLE_DEPTH;
			sq = a * a;
			pow_lut[i] = 32'((sq * root5_q12(sq << 28)) >> 28);
		end
	end

	function automatic logic [15:0] tone_map(logic [15:0] v, logic [15:0] g);
		longint unsigned s, x, t, num, den, c, pos, idx, w, lo, hi, r;
		s = (longint'(v) * g + 128) >> 8;
		if (s > 65535) s = 65535;
		x = (s > 16) ? s - 16 : 0;
		t = 406323 * x;
		num = x * (t + 64'd134217728);
		den = x * (t + 64'd456340275) + 64'd65970697667;
		c = ((num >> 12) << 16) / (den >> 12);
		if (c > 65535) c = 65535;
		pos = c * POW_TABLE_DEPTH;
		idx = pos >> 16;
		w = pos & 16'hFFFF;
		if (idx >= POW_TABLE_DEPTH) idx = POW_TABLE_DEPTH - 1;
		lo = pow_lut[idx];
		hi = pow_lut[idx + 1];
		if (hi < lo) hi = lo;
		r = lo + (((hi - lo) * w + 32768) >> 16);
		if (r > 65535) r = 65535;
		return r[15:0];
	endfunction

	assign pending = pixel_q.size();

	// Track gain, queue predictions, compare result beats
	always @(posedge clk or negedge arst_n) begin
		logic [47:0] exp_pix;
		if (!arst_n) begin
			gain_q8 <= 16'd256;
			fail_count <= 0;
			pixel_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) gain_q8 <= cfg_data;
			if (s_tvalid && s_tready)
				pixel_q.push_back({tone_map(s_tdata[47:32], gain_q8),
					tone_map(s_tdata[31:16], gain_q8), tone_map(s_tdata[15:0], gain_q8)});
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_pix = pixel_q.pop_front();
					for (int k = 0; k < 3; k++)
						if (exp_pix[16*k +: 16] !== m_tdata[16*k +: 16])
							$display("%0t: channel %0d expected %h actual %h", $time, k,
								exp_pix[16*k +: 16], m_tdata[16*k +: 16]);
					if (exp_pix !== m_tdata) fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the filmic tone mapper
// Drives directed and random pixels under several exposure gains with random
// idling on both sides, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY = 24;
	localparam int LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	int          fail_count, pending;
	int          send_idle = 16, recv_idle = 57;
	bit          hold_off = 1'b0;
	int          cycles = 0;

	always #4 clk = ~clk;

	filmic_tone_map_rgb DUT (.*);
	ftm_checker u_checker (.*);

	// Receiver: random stall, or a long hold-off
	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(3))
			0: return 16'($urandom_range(40));
			1: return 16'($urandom_range(8192));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		// Drop valid for each idle cycle, then offer the beat until taken
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_gain(logic [15:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed();
		send_pixel(16'h0000, 16'hFFFF, 16'h0010);
		send_pixel(16'h0011, 16'h0001, 16'h1000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h5555, 16'hAAAA, 16'h8000);
		send_pixel(16'h000F, 16'h0100, 16'h7FFF);
	endtask

	initial begin
		logic [15:0] gains [6];
		gains = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd100};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (gains[p]) begin
			if (p == 1) begin
				send_idle = 57;
				recv_idle = 16;
			end
			if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_gain(gains[p]);
			directed();
			if (p == 0) begin
				// Hold the output off so the pipeline fills and stalls input
				hold_off = 1'b1;
				fork
					begin repeat (200) @(posedge clk); hold_off = 1'b0; end
					repeat (60) send_pixel(rand_chan(), rand_chan(), rand_chan());
				join
				drain();
			end
			repeat (270) send_pixel(rand_chan(), rand_chan(), rand_chan());
			drain();
		end
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ftm_pkg.sv
rtl/ftm_ctrl.sv
rtl/ftm_lane.sv
rtl/filmic_tone_map_rgb.sv
dv/ftm_checker.sv
dv/tb_top.sv
